>>> rtl/core/cpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and saturating fixed-point helpers for the
// contact position correction pipeline. No dependencies.
package cpc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_W     = 32 + FRAC_BITS;  // dividend and quotient width
  localparam int BETA_W    = 17;
  localparam int SLOP_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = BETA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_BETA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOP = CFG_IDX_W'(1);

  localparam logic [BETA_W-1:0] BETA_RESET = BETA_W'(13107);
  localparam logic [SLOP_W-1:0] SLOP_RESET = SLOP_W'(328);

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Per-item data that rides along the divider
  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] rax;
    logic signed [31:0] ray;
    logic signed [31:0] rbx;
    logic signed [31:0] rby;
    logic               tol;
    logic               kpos;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return S32_MAX;
    end else if (v < -64'sd2147483648) begin
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  // Full product, floor shift, saturate
  function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p >>> FRAC_BITS;
    return sat32(p);
  endfunction

  function automatic logic signed [31:0] fadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) + 64'(b));
  endfunction

  function automatic logic signed [31:0] fsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return sat32(64'(a) - 64'(b));
  endfunction

  function automatic logic signed [31:0] hi32(input logic [63:0] w);
    return $signed(w[63:32]);
  endfunction

  function automatic logic signed [31:0] lo32(input logic [63:0] w);
    return $signed(w[31:0]);
  endfunction

endpackage

>>> rtl/core/cpc_geom.sv
`timescale 1ns / 1ps
// Front pipeline: world transform, lever arms, separation, effective mass
// and bias. Nine register stages. Depends on cpc_pkg.
module cpc_geom import cpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [63:0]           pose_a_position_i,
  input  logic [63:0]           pose_a_rotation_i,
  input  logic [63:0]           pose_b_position_i,
  input  logic [63:0]           pose_b_rotation_i,
  input  logic [63:0]           mass_a_i,
  input  logic [63:0]           mass_b_i,
  input  logic [63:0]           plane_point_local_i,
  input  logic [63:0]           clip_point_local_i,
  input  logic [63:0]           normal_local_i,
  input  logic [BETA_W-1:0]     beta_i,
  input  logic [SLOP_W-1:0]     slop_i,
  output logic                  valid_o,
  output logic [DIV_W-1:0]      num_o,
  output logic [30:0]           den_o,
  output side_t                 side_o
);

  logic [9:1] v_q;

  // stage 1: rotation products
  logic signed [31:0] m_q [12];
  logic signed [31:0] pax1_q, pay1_q, pbx1_q, pby1_q;
  logic signed [31:0] ima1_q, iia1_q, imb1_q, iib1_q;
  // stage 2: world normal and points
  logic signed [31:0] nx2_q, ny2_q, plx_q, ply_q, clx_q, cly_q;
  logic signed [31:0] pax2_q, pay2_q, pbx2_q, pby2_q;
  logic signed [31:0] ima2_q, iia2_q, imb2_q, iib2_q;
  // stage 3: differences
  logic signed [31:0] nx3_q, ny3_q, dx_q, dy_q;
  logic signed [31:0] rax3_q, ray3_q, rbx3_q, rby3_q;
  logic signed [31:0] ima3_q, iia3_q, imb3_q, iib3_q;
  // stage 4: dot and cross products
  logic signed [31:0] p_q [6];
  logic signed [31:0] nx4_q, ny4_q, rax4_q, ray4_q, rbx4_q, rby4_q;
  logic signed [31:0] ima4_q, iia4_q, imb4_q, iib4_q;
  // stage 5
  logic signed [31:0] sep_q, ran5_q, rbn5_q;
  logic signed [31:0] nx5_q, ny5_q, rax5_q, ray5_q, rbx5_q, rby5_q;
  logic signed [31:0] ima5_q, iia5_q, imb5_q, iib5_q;
  // stage 6
  logic signed [31:0] q0_q, q1_q, ss_q, ran6_q, rbn6_q;
  logic signed [31:0] ima6_q, imb6_q;
  logic               tol6_q;
  logic signed [31:0] nx6_q, ny6_q, rax6_q, ray6_q, rbx6_q, rby6_q;
  // stage 7
  logic signed [31:0] r0_q, r1_q, cm_q, ima7_q, imb7_q;
  logic               tol7_q;
  logic signed [31:0] nx7_q, ny7_q, rax7_q, ray7_q, rbx7_q, rby7_q;
  // stage 8
  logic signed [31:0] k2_q, r1b_q, c_q;
  logic               tol8_q;
  logic signed [31:0] nx8_q, ny8_q, rax8_q, ray8_q, rbx8_q, rby8_q;
  // stage 9
  logic [DIV_W-1:0]   num_q;
  logic signed [31:0] k_q;
  side_t              side_q;

  logic signed [33:0] nsep_d, thr_d;
  logic               tol_d;
  logic signed [31:0] kfin_d, cneg_d;
  logic [31:0]        negc_d;

  always_comb begin
    nsep_d = -34'(sep_q);
    thr_d  = $signed({18'd0, slop_i}) * 34'sd3;
    tol_d  = (nsep_d <= thr_d);
    kfin_d = fadd(k2_q, r1b_q);
    cneg_d = c_q;
    negc_d = 32'(~cneg_d) + 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[8:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // 1
    m_q[0]  <= fmul(hi32(pose_a_rotation_i), hi32(normal_local_i));
    m_q[1]  <= fmul(lo32(pose_a_rotation_i), lo32(normal_local_i));
    m_q[2]  <= fmul(lo32(pose_a_rotation_i), hi32(normal_local_i));
    m_q[3]  <= fmul(hi32(pose_a_rotation_i), lo32(normal_local_i));
    m_q[4]  <= fmul(hi32(pose_a_rotation_i), hi32(plane_point_local_i));
    m_q[5]  <= fmul(lo32(pose_a_rotation_i), lo32(plane_point_local_i));
    m_q[6]  <= fmul(lo32(pose_a_rotation_i), hi32(plane_point_local_i));
    m_q[7]  <= fmul(hi32(pose_a_rotation_i), lo32(plane_point_local_i));
    m_q[8]  <= fmul(hi32(pose_b_rotation_i), hi32(clip_point_local_i));
    m_q[9]  <= fmul(lo32(pose_b_rotation_i), lo32(clip_point_local_i));
    m_q[10] <= fmul(lo32(pose_b_rotation_i), hi32(clip_point_local_i));
    m_q[11] <= fmul(hi32(pose_b_rotation_i), lo32(clip_point_local_i));
    pax1_q <= hi32(pose_a_position_i);
    pay1_q <= lo32(pose_a_position_i);
    pbx1_q <= hi32(pose_b_position_i);
    pby1_q <= lo32(pose_b_position_i);
    ima1_q <= hi32(mass_a_i);
    iia1_q <= lo32(mass_a_i);
    imb1_q <= hi32(mass_b_i);
    iib1_q <= lo32(mass_b_i);
    // 2
    nx2_q <= fsub(m_q[0], m_q[1]);
    ny2_q <= fadd(m_q[2], m_q[3]);
    plx_q <= fadd(fsub(m_q[4], m_q[5]), pax1_q);
    ply_q <= fadd(fadd(m_q[6], m_q[7]), pay1_q);
    clx_q <= fadd(fsub(m_q[8], m_q[9]), pbx1_q);
    cly_q <= fadd(fadd(m_q[10], m_q[11]), pby1_q);
    pax2_q <= pax1_q; pay2_q <= pay1_q; pbx2_q <= pbx1_q; pby2_q <= pby1_q;
    ima2_q <= ima1_q; iia2_q <= iia1_q; imb2_q <= imb1_q; iib2_q <= iib1_q;
    // 3
    nx3_q  <= nx2_q;
    ny3_q  <= ny2_q;
    dx_q   <= fsub(clx_q, plx_q);
    dy_q   <= fsub(cly_q, ply_q);
    rax3_q <= fsub(clx_q, pax2_q);
    ray3_q <= fsub(cly_q, pay2_q);
    rbx3_q <= fsub(clx_q, pbx2_q);
    rby3_q <= fsub(cly_q, pby2_q);
    ima3_q <= ima2_q; iia3_q <= iia2_q; imb3_q <= imb2_q; iib3_q <= iib2_q;
    // 4
    p_q[0] <= fmul(dx_q, nx3_q);
    p_q[1] <= fmul(dy_q, ny3_q);
    p_q[2] <= fmul(rax3_q, ny3_q);
    p_q[3] <= fmul(ray3_q, nx3_q);
    p_q[4] <= fmul(rbx3_q, ny3_q);
    p_q[5] <= fmul(rby3_q, nx3_q);
    nx4_q <= nx3_q; ny4_q <= ny3_q;
    rax4_q <= rax3_q; ray4_q <= ray3_q; rbx4_q <= rbx3_q; rby4_q <= rby3_q;
    ima4_q <= ima3_q; iia4_q <= iia3_q; imb4_q <= imb3_q; iib4_q <= iib3_q;
    // 5
    sep_q  <= fadd(p_q[0], p_q[1]);
    ran5_q <= fsub(p_q[2], p_q[3]);
    rbn5_q <= fsub(p_q[4], p_q[5]);
    nx5_q <= nx4_q; ny5_q <= ny4_q;
    rax5_q <= rax4_q; ray5_q <= ray4_q; rbx5_q <= rbx4_q; rby5_q <= rby4_q;
    ima5_q <= ima4_q; iia5_q <= iia4_q; imb5_q <= imb4_q; iib5_q <= iib4_q;
    // 6
    q0_q   <= fmul(ran5_q, iia5_q);
    q1_q   <= fmul(rbn5_q, iib5_q);
    ss_q   <= fadd(sep_q, $signed({16'd0, slop_i}));
    tol6_q <= tol_d;
    ran6_q <= ran5_q; rbn6_q <= rbn5_q;
    ima6_q <= ima5_q; imb6_q <= imb5_q;
    nx6_q <= nx5_q; ny6_q <= ny5_q;
    rax6_q <= rax5_q; ray6_q <= ray5_q; rbx6_q <= rbx5_q; rby6_q <= rby5_q;
    // 7
    r0_q   <= fmul(q0_q, ran6_q);
    r1_q   <= fmul(q1_q, rbn6_q);
    cm_q   <= fmul($signed({15'd0, beta_i}), ss_q);
    ima7_q <= ima6_q; imb7_q <= imb6_q; tol7_q <= tol6_q;
    nx7_q <= nx6_q; ny7_q <= ny6_q;
    rax7_q <= rax6_q; ray7_q <= ray6_q; rbx7_q <= rbx6_q; rby7_q <= rby6_q;
    // 8: bias clamps at zero
    k2_q   <= fadd(fadd(ima7_q, r0_q), imb7_q);
    r1b_q  <= r1_q;
    c_q    <= (cm_q > 32'sd0) ? 32'sd0 : cm_q;
    tol8_q <= tol7_q;
    nx8_q <= nx7_q; ny8_q <= ny7_q;
    rax8_q <= rax7_q; ray8_q <= ray7_q; rbx8_q <= rbx7_q; rby8_q <= rby7_q;
    // 9
    k_q    <= kfin_d;
    num_q  <= {negc_d, FRAC_BITS'(0)};
    side_q <= '{nx: nx8_q, ny: ny8_q, rax: rax8_q, ray: ray8_q,
                rbx: rbx8_q, rby: rby8_q, tol: tol8_q, kpos: (kfin_d > 32'sd0)};
  end

  assign valid_o = v_q[9];
  assign num_o   = num_q;
  assign den_o   = k_q[30:0];
  assign side_o  = side_q;

endmodule

>>> rtl/core/cpc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, DIV_W stages.
// Carries side data alongside. Depends on cpc_pkg.
module cpc_div import cpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [30:0]      den_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [DIV_W-1:0] quo_o,
  output side_t            side_o
);

  // index 0 is the input, index s+1 the register after stage s
  logic             v_q    [DIV_W+1];
  logic [30:0]      rem_q  [DIV_W+1];
  logic [DIV_W-1:0] nq_q   [DIV_W+1];  // dividend bits out, quotient bits in
  logic [30:0]      den_q  [DIV_W+1];
  side_t            side_q [DIV_W+1];

  assign v_q[0]    = valid_i;
  assign rem_q[0]  = '0;
  assign nq_q[0]   = num_i;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar s = 0; s < DIV_W; s++) begin : g_stage
    logic [31:0] trial;
    logic        ge;
    assign trial = {rem_q[s], nq_q[s][DIV_W-1]};
    assign ge    = (trial >= {1'b0, den_q[s]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= ge ? 31'(trial - {1'b0, den_q[s]}) : trial[30:0];
      nq_q[s+1]   <= {nq_q[s][DIV_W-2:0], ge};
      den_q[s+1]  <= den_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = v_q[DIV_W];
  assign quo_o   = nq_q[DIV_W];
  assign side_o  = side_q[DIV_W];

endmodule

>>> rtl/core/cpc_apply.sv
`timescale 1ns / 1ps
// Back pipeline: lambda clamp, linear impulse and angular deltas.
// Four register stages, the last is the output register. Depends on cpc_pkg.
module cpc_apply import cpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [DIV_W-1:0]   quo_i,
  input  side_t              side_i,
  output logic               valid_o,
  output logic signed [31:0] impulse_x_o,
  output logic signed [31:0] impulse_y_o,
  output logic signed [31:0] angular_delta_a_o,
  output logic signed [31:0] angular_delta_b_o,
  output logic               within_tolerance_o
);

  logic [4:1]         v_q;
  logic signed [31:0] lam_q;
  side_t              s1_q, s2_q;
  logic signed [31:0] ix_q, iy_q, ix3_q, iy3_q;
  logic signed [31:0] m_q [4];
  logic               tol3_q;
  logic signed [31:0] ix4_q, iy4_q, da_q, db_q;
  logic               tol4_q;
  logic signed [31:0] lam_d, ca_d;

  always_comb begin
    if (!side_i.kpos) begin
      lam_d = '0;
    end else if (|quo_i[DIV_W-1:31]) begin
      lam_d = S32_MAX;
    end else begin
      lam_d = $signed(quo_i[31:0]);
    end
    ca_d = fsub(m_q[0], m_q[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    lam_q  <= lam_d;
    s1_q   <= side_i;
    ix_q   <= fmul(s1_q.nx, lam_q);
    iy_q   <= fmul(s1_q.ny, lam_q);
    s2_q   <= s1_q;
    m_q[0] <= fmul(s2_q.rax, iy_q);
    m_q[1] <= fmul(s2_q.ray, ix_q);
    m_q[2] <= fmul(s2_q.rbx, iy_q);
    m_q[3] <= fmul(s2_q.rby, ix_q);
    ix3_q  <= ix_q;
    iy3_q  <= iy_q;
    tol3_q <= s2_q.tol;
    ix4_q  <= ix3_q;
    iy4_q  <= iy3_q;
    da_q   <= sat32(-64'(ca_d));
    db_q   <= fsub(m_q[2], m_q[3]);
    tol4_q <= tol3_q;
  end

  assign valid_o            = v_q[4];
  assign impulse_x_o        = ix4_q;
  assign impulse_y_o        = iy4_q;
  assign angular_delta_a_o  = da_q;
  assign angular_delta_b_o  = db_q;
  assign within_tolerance_o = tol4_q;

endmodule

>>> rtl/core/contact_position_correction.sv
`timescale 1ns / 1ps
// Top level of the contact position correction pipeline: config registers,
// front pipeline, divider and back pipeline. Depends on cpc_pkg, cpc_geom,
// cpc_div, cpc_apply.
//
//   port group   direction  handshake
//   item in      in         start_i, accepted when busy_o is low
//   result out   out        done_o strobe, one cycle, no backpressure
//   config       in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// One item per cycle; each result passes 9 front stages, one divider stage
// per quotient bit and 4 back stages.
// busy_o stays low: nothing in the pipe ever waits.
// Reset clears the valid bits and loads the register defaults.
module contact_position_correction import cpc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [63:0]           pose_a_position_i,
  input  logic [63:0]           pose_a_rotation_i,
  input  logic [63:0]           pose_b_position_i,
  input  logic [63:0]           pose_b_rotation_i,
  input  logic [63:0]           mass_a_i,
  input  logic [63:0]           mass_b_i,
  input  logic [63:0]           plane_point_local_i,
  input  logic [63:0]           clip_point_local_i,
  input  logic [63:0]           normal_local_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic signed [31:0]    impulse_x_o,
  output logic signed [31:0]    impulse_y_o,
  output logic signed [31:0]    angular_delta_a_o,
  output logic signed [31:0]    angular_delta_b_o,
  output logic                  within_tolerance_o
);

  logic [BETA_W-1:0] beta_q;
  logic [SLOP_W-1:0] slop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RESET;
      slop_q <= SLOP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BETA: beta_q <= cfg_data_i[BETA_W-1:0];
        CFG_SLOP: slop_q <= cfg_data_i[SLOP_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic             g_valid, d_valid;
  logic [DIV_W-1:0] g_num, d_quo;
  logic [30:0]      g_den;
  side_t            g_side, d_side;

  cpc_geom u_geom (
    .clk_i, .rst_ni,
    .valid_i             (start_i && !busy_o),
    .pose_a_position_i, .pose_a_rotation_i,
    .pose_b_position_i, .pose_b_rotation_i,
    .mass_a_i, .mass_b_i,
    .plane_point_local_i, .clip_point_local_i, .normal_local_i,
    .beta_i              (beta_q),
    .slop_i              (slop_q),
    .valid_o             (g_valid),
    .num_o               (g_num),
    .den_o               (g_den),
    .side_o              (g_side)
  );

  cpc_div u_div (
    .clk_i, .rst_ni,
    .valid_i (g_valid),
    .num_i   (g_num),
    .den_i   (g_den),
    .side_i  (g_side),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .side_o  (d_side)
  );

  cpc_apply u_apply (
    .clk_i, .rst_ni,
    .valid_i (d_valid),
    .quo_i   (d_quo),
    .side_i  (d_side),
    .valid_o (done_o),
    .impulse_x_o, .impulse_y_o,
    .angular_delta_a_o, .angular_delta_b_o,
    .within_tolerance_o
  );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for contact_position_correction: drives contact items, predicts
// impulses in Q16.16 and checks each result in order. Depends on cpc_pkg.
module tb_top;
  import cpc_pkg::*;

  typedef struct {
    logic [63:0] pa_pos, pa_rot, pb_pos, pb_rot, m_a, m_b, plane, clip, nrm;
  } contact_t;

  typedef struct {
    logic signed [31:0] ix, iy, da, db;
    logic               tol;
  } impulse_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [63:0] pose_a_position_i = '0, pose_a_rotation_i = '0;
  logic [63:0] pose_b_position_i = '0, pose_b_rotation_i = '0;
  logic [63:0] mass_a_i = '0, mass_b_i = '0;
  logic [63:0] plane_point_local_i = '0, clip_point_local_i = '0, normal_local_i = '0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_BETA;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic done_o;
  logic signed [31:0] impulse_x_o, impulse_y_o, angular_delta_a_o, angular_delta_b_o;
  logic within_tolerance_o;

  contact_position_correction i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  contact_t pending_items[$];
  impulse_t expected_impulses[$];
  logic [BETA_W-1:0] beta_q = BETA_RESET;
  logic [SLOP_W-1:0] slop_q = SLOP_RESET;
  int  n_errors = 0;
  int  n_checked = 0;
  int  n_nonzero = 0;
  bit  quiet = 1'b0;     // driver never idles while set
  bit  hold = 1'b0;      // driver holds off while set

  // Predictor arithmetic, written with 64-bit intermediates
  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction
  function automatic longint mulq(longint a, longint b);
    return sat((a * b) >>> FRAC_BITS);
  endfunction
  function automatic longint hi(logic [63:0] w);
    return longint'($signed(w[63:32]));
  endfunction
  function automatic longint lo(logic [63:0] w);
    return longint'($signed(w[31:0]));
  endfunction

  function automatic impulse_t predict_impulse(contact_t c);
    impulse_t r;
    longint ca, sa, cb, sb, nx, ny, plx, ply, clx, cly, dx, dy, sep;
    longint rax, ray, rbx, rby, ran, rbn, k, corr, lam, ix, iy, slop;
    ca = hi(c.pa_rot); sa = lo(c.pa_rot);
    cb = hi(c.pb_rot); sb = lo(c.pb_rot);
    slop = longint'(slop_q);
    nx = sat(mulq(ca, hi(c.nrm)) - mulq(sa, lo(c.nrm)));
    ny = sat(mulq(sa, hi(c.nrm)) + mulq(ca, lo(c.nrm)));
    plx = sat(sat(mulq(ca, hi(c.plane)) - mulq(sa, lo(c.plane))) + hi(c.pa_pos));
    ply = sat(sat(mulq(sa, hi(c.plane)) + mulq(ca, lo(c.plane))) + lo(c.pa_pos));
    clx = sat(sat(mulq(cb, hi(c.clip)) - mulq(sb, lo(c.clip))) + hi(c.pb_pos));
    cly = sat(sat(mulq(sb, hi(c.clip)) + mulq(cb, lo(c.clip))) + lo(c.pb_pos));
    dx = sat(clx - plx); dy = sat(cly - ply);
    sep = sat(mulq(dx, nx) + mulq(dy, ny));
    rax = sat(clx - hi(c.pa_pos)); ray = sat(cly - lo(c.pa_pos));
    rbx = sat(clx - hi(c.pb_pos)); rby = sat(cly - lo(c.pb_pos));
    ran = sat(mulq(rax, ny) - mulq(ray, nx));
    rbn = sat(mulq(rbx, ny) - mulq(rby, nx));
    k = sat(hi(c.m_a) + mulq(mulq(ran, lo(c.m_a)), ran));
    k = sat(k + hi(c.m_b));
    k = sat(k + mulq(mulq(rbn, lo(c.m_b)), rbn));
    corr = mulq(longint'(beta_q), sat(sep + slop));
    if (corr > 0) corr = 0;
    lam = 0;
    if (k > 0) lam = sat((-corr * (64'sd1 <<< FRAC_BITS)) / k);
    ix = mulq(nx, lam); iy = mulq(ny, lam);
    r.ix = 32'(ix); r.iy = 32'(iy);
    r.da = 32'(sat(-sat(mulq(rax, iy) - mulq(ray, ix))));
    r.db = 32'(sat(mulq(rbx, iy) - mulq(rby, ix)));
    r.tol = (-sep <= 3 * slop);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    n_errors++;
  endtask

  // Driver: presents items at the falling edge, holds until accepted
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_impulses.push_back(predict_impulse('{pose_a_position_i,
          pose_a_rotation_i, pose_b_position_i, pose_b_rotation_i, mass_a_i, mass_b_i,
          plane_point_local_i, clip_point_local_i, normal_local_i}));
      end
      if (!(start_i && busy_o)) begin
        if (pending_items.size() > 0 && !hold && (quiet || $urandom_range(99) >= 10)) begin
          contact_t c;
          c = pending_items.pop_front();
          start_i <= 1'b1;
          pose_a_position_i <= c.pa_pos; pose_a_rotation_i <= c.pa_rot;
          pose_b_position_i <= c.pb_pos; pose_b_rotation_i <= c.pb_rot;
          mass_a_i <= c.m_a; mass_b_i <= c.m_b;
          plane_point_local_i <= c.plane; clip_point_local_i <= c.clip;
          normal_local_i <= c.nrm;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_impulses.size() == 0) begin
        report_mismatch("unexpected result", impulse_x_o, '0);
      end else begin
        impulse_t e;
        e = expected_impulses.pop_front();
        if (impulse_x_o !== e.ix) report_mismatch("impulse_x", impulse_x_o, e.ix);
        if (impulse_y_o !== e.iy) report_mismatch("impulse_y", impulse_y_o, e.iy);
        if (angular_delta_a_o !== e.da)
          report_mismatch("angular_delta_a", angular_delta_a_o, e.da);
        if (angular_delta_b_o !== e.db)
          report_mismatch("angular_delta_b", angular_delta_b_o, e.db);
        if (within_tolerance_o !== e.tol)
          report_mismatch("within_tolerance", 32'(within_tolerance_o), 32'(e.tol));
        if (e.ix != 0 || e.iy != 0) n_nonzero++;
        n_checked++;
      end
    end
  end

  function automatic logic [63:0] pack2(int x, int y);
    return {32'(x), 32'(y)};
  endfunction
  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction
  // Small signed Q16.16 value in +-range units
  function automatic int rq(int range);
    return $urandom_range(2 * range * 65536) - range * 65536;
  endfunction

  // Plausible contact: unit-ish rotations, small offsets, non-negative masses
  function automatic contact_t plausible_contact();
    contact_t c;
    int ang_c, ang_s;
    ang_c = rq(1); ang_s = rq(1);
    c.pa_pos = pack2(rq(8), rq(8));
    c.pa_rot = pack2(ang_c, ang_s);
    c.pb_pos = pack2(rq(8), rq(8));
    c.pb_rot = pack2(rq(1), rq(1));
    c.m_a = pack2($urandom_range(4 << 16), $urandom_range(4 << 16));
    c.m_b = pack2($urandom_range(4 << 16), $urandom_range(4 << 16));
    c.plane = pack2(rq(2), rq(2));
    c.clip = pack2(rq(2), rq(2));
    c.nrm = pack2(rq(1), rq(1));
    return c;
  endfunction

  function automatic contact_t noise_contact();
    return '{rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(), rnd64(),
             rnd64(), rnd64()};
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || start_i || expected_impulses.size() > 0)
      @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BETA) beta_q = val;
    else if (idx == CFG_SLOP) slop_q = val[SLOP_W-1:0];
  endtask

  task automatic load_random(int count);
    for (int i = 0; i < count; i++)
      pending_items.push_back($urandom_range(99) < 80 ? plausible_contact()
                                                      : noise_contact());
  endtask

  initial begin
    contact_t c;
    logic [CFG_DATA_W-1:0] betas[4];
    logic [CFG_DATA_W-1:0] slops[4];
    betas = '{17'd0, 17'd65536, 17'd1, 17'h1ffff};
    slops = '{17'd0, 17'd65535, 17'd1, 17'd3000};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: resting contact, deep penetration, separated, zero/neg mass, extremes
    c = '{pack2(0, 0), pack2(65536, 0), pack2(0, 0), pack2(65536, 0),
          pack2(65536, 65536), pack2(65536, 65536), pack2(0, 0), pack2(0, -65536),
          pack2(0, 65536)};
    pending_items.push_back(c);
    c.clip = pack2(65536, -3 * 65536); pending_items.push_back(c);
    c.clip = pack2(0, 5 * 65536); pending_items.push_back(c);
    c.clip = pack2(0, -65536); c.m_a = '0; c.m_b = '0; pending_items.push_back(c);
    c.m_a = pack2(-65536, -65536); pending_items.push_back(c);
    c.m_a = pack2(1, 0); c.m_b = '0; pending_items.push_back(c);
    c = '{default: 64'h7fffffff_7fffffff}; pending_items.push_back(c);
    c = '{default: 64'h80000000_80000000}; pending_items.push_back(c);
    c = '{default: 64'hffffffff_ffffffff}; pending_items.push_back(c);
    c = '{default: 64'h0}; pending_items.push_back(c);
    c = '{default: 64'h80000000_7fffffff}; c.m_a = 64'h00000001_00000001;
    pending_items.push_back(c);
    wait_drained();

    // Pressure phase without idle, then config sweeps with random content
    quiet = 1'b1;
    load_random(300);
    wait_drained();
    quiet = 1'b0;
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_BETA, betas[p]);
      write_reg(CFG_SLOP, slops[p]);
      load_random(200);
      hold = 1'b1;
      repeat (20) @(posedge clk_i);
      hold = 1'b0;
      wait_drained();
    end
    write_reg(CFG_BETA, 17'd13107);
    write_reg(CFG_SLOP, 17'd328);
    load_random(300);
    while (pending_items.size() > 0) @(posedge clk_i);
    hold = 1'b1;
    while (expected_impulses.size() > 0 || start_i) @(posedge clk_i);
    hold = 1'b0;
    load_random(300);
    wait_drained();

    $display("Checked %0d contacts (%0d with nonzero impulse) over 6 register settings.",
             n_checked, n_nonzero);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> contact_position_correction.f
rtl/core/cpc_pkg.sv
rtl/core/cpc_geom.sv
rtl/core/cpc_div.sv
rtl/core/cpc_apply.sv
rtl/core/contact_position_correction.sv
test/tb_top.sv
